// File: design/pot_pkg.sv
// shared types and constants for the perceptron online trainer
// no dependencies; imported by every module of the block
package pot_pkg;

    localparam int NUM_FEATURES_DEF = 6;
    localparam int MAX_FEATS        = 6;
    localparam int DATA_W           = 32;
    localparam int PROD_W           = 2 * DATA_W;
    localparam int ACC_W            = PROD_W + 3;
    localparam int SHIFT_BASE       = 16;
    localparam int IN_TDATA_W       = (MAX_FEATS + 1) * DATA_W;
    localparam int OUT_TDATA_W      = 40;

    localparam logic [3:0]        RATE_RESET = 4'd2;
    localparam logic signed [33:0] ONE_Q16   = 34'sd65536;

    typedef enum logic [1:0] {
        OP_TRAIN = 2'd0,
        OP_EVAL  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SPARE = 2'd3
    } opcode_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic mul_en;
        logic mul_upd;
        logic acc_en;
        logic err_en;
        logic wr_en;
        logic out_load;
        logic out_zero;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// File: design/perceptron_online_trainer.sv
// top level: online perceptron trainer; instantiates pot_ctrl and pot_dp, needs pot_pkg
// sequence: train captures, multiplies and sums, computes the error, updates the weights
//   and loads the result; evaluate skips the update, clear zeroes the weights and result;
//   a result held by m_tready holds the block too; the next item waits until it loads;
//   all products come from one shared 32x32 multiplier
// reset: aresetn synchronous active low; weights cleared, rate_shift set to 2
module perceptron_online_trainer import pot_pkg::*; #(
    parameter int NUM_FEATURES = NUM_FEATURES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // feat_speed_x, feat_speed_y, feat_angle, feat_accel, feat_brake,
    // feat_steer, angle_now (32 bits each)
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // observed (1 bit), error_value (32 bits), zero padding
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [3:0]             cfg_data
);

    localparam int IDX_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int CNT_W = $clog2(NUM_FEATURES + 1);

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [IDX_W-1:0] rd_idx, wr_idx;

    assign cfg_ready = 1'b1;

    pot_ctrl #(
        .NUM_FEATURES(NUM_FEATURES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .opcode  (s_tuser),
        .status  (status),
        .cmd     (cmd),
        .rd_idx  (rd_idx),
        .wr_idx  (wr_idx)
    );

    pot_dp #(
        .NUM_FEATURES(NUM_FEATURES),
        .IDX_W       (IDX_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .wr_idx   (wr_idx),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: design/pot_ctrl.sv
// controller state machine: sequences capture, sum, error, update, clear and result
// depends on pot_pkg
module pot_ctrl import pot_pkg::*; #(
    parameter int NUM_FEATURES = NUM_FEATURES_DEF,
    parameter int IDX_W        = 3,
    parameter int CNT_W        = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       opcode,
    input  dp_status_t       status,
    output ctrl_cmd_t        cmd,
    output logic [IDX_W-1:0] rd_idx,
    output logic [IDX_W-1:0] wr_idx
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAC  = 5'b00010,
        S_ERR  = 5'b00100,
        S_UPD  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_FEATURES);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_m1;
    logic             train_reg, train_next;
    logic             zero_reg, zero_next;

    assign cnt_m1 = cnt_reg - 1'b1;
    assign rd_idx = cnt_reg[IDX_W-1:0];
    assign wr_idx = cnt_m1[IDX_W-1:0];
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        train_next = train_reg;
        zero_next  = zero_reg;
        cmd.out_zero = zero_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    if (opcode == OP_CLEAR) begin
                        cmd.clear  = 1'b1;
                        zero_next  = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        zero_next  = 1'b0;
                        train_next = (opcode == OP_TRAIN);
                        state_next = S_MAC;
                    end
                end
            end
            S_MAC: begin
                cmd.mul_en = (cnt_reg != CNT_LAST);
                cmd.acc_en = (cnt_reg != '0);
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_ERR;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ERR: begin
                cmd.err_en = 1'b1;
                cnt_next   = '0;
                state_next = train_reg ? S_UPD : S_DONE;
            end
            S_UPD: begin
                cmd.mul_en  = (cnt_reg != CNT_LAST);
                cmd.mul_upd = 1'b1;
                cmd.wr_en   = (cnt_reg != '0);
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            train_reg <= 1'b0;
            zero_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            train_reg <= train_next;
            zero_reg  <= zero_next;
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over an untaken result");

    a_write_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> (state_reg == S_UPD) && train_reg && (cnt_reg != '0))
        else $error("weight write outside the update phase");

endmodule

// File: design/pot_dp.sv
// datapath: weight and feature registers, shared multiplier, accumulator,
// error and update arithmetic, result register; depends on pot_pkg
module pot_dp import pot_pkg::*; #(
    parameter int NUM_FEATURES = NUM_FEATURES_DEF,
    parameter int IDX_W        = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   cfg_valid,
    input  logic [3:0]             cfg_data,
    input  ctrl_cmd_t              cmd,
    input  logic [IDX_W-1:0]       rd_idx,
    input  logic [IDX_W-1:0]       wr_idx,
    output dp_status_t             status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] S32_MIN = -PROD_W'(64'sh0000_0000_8000_0000);

    logic signed [DATA_W-1:0] weight_reg [NUM_FEATURES];
    logic signed [DATA_W-1:0] feat_reg   [NUM_FEATURES];
    logic signed [DATA_W-1:0] prev_angle_reg, angle_now_reg;
    logic signed [DATA_W-1:0] err_reg, err_next;
    logic                     obs_reg, obs_next;
    logic signed [DATA_W-1:0] wold_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [3:0]               rate_reg;
    logic                     m_tvalid_reg;
    logic                     out_obs_reg;
    logic signed [DATA_W-1:0] out_err_reg;

    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [32:0]       target;
    logic signed [33:0]       err_raw;
    logic [5:0]               shamt;
    logic signed [PROD_W-1:0] delta, wsum;
    logic signed [DATA_W-1:0] wnew;

    assign mul_a = cmd.mul_upd ? feat_reg[rd_idx] : weight_reg[rd_idx];
    assign mul_b = cmd.mul_upd ? err_reg : feat_reg[rd_idx];

    always_comb begin
        obs_next = ~acc_reg[ACC_W-1];
        target   = 33'(angle_now_reg) - 33'(prev_angle_reg);
        err_raw  = 34'(target) - (obs_next ? ONE_Q16 : 34'sd0);
        if (err_raw > 34'sd2147483647) begin
            err_next = 32'sh7FFF_FFFF;
        end else if (err_raw < -34'sd2147483648) begin
            err_next = 32'sh8000_0000;
        end else begin
            err_next = err_raw[DATA_W-1:0];
        end
    end

    always_comb begin
        shamt = 6'(SHIFT_BASE) + {2'b00, rate_reg};
        delta = prod_reg >>> shamt;
        wsum  = PROD_W'(wold_reg) + delta;
        if (wsum > S32_MAX) begin
            wnew = 32'sh7FFF_FFFF;
        end else if (wsum < S32_MIN) begin
            wnew = 32'sh8000_0000;
        end else begin
            wnew = wsum[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
            for (int i = 0; i < NUM_FEATURES; i++) begin
                weight_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                rate_reg <= cfg_data;
            end
            if (cmd.clear) begin
                for (int i = 0; i < NUM_FEATURES; i++) begin
                    weight_reg[i] <= '0;
                end
            end else if (cmd.wr_en) begin
                weight_reg[wr_idx] <= wnew;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int i = 0; i < NUM_FEATURES; i++) begin
                feat_reg[i] <= s_tdata[i*DATA_W +: DATA_W];
            end
            prev_angle_reg <= s_tdata[2*DATA_W +: DATA_W];
            angle_now_reg  <= s_tdata[MAX_FEATS*DATA_W +: DATA_W];
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
            wold_reg <= weight_reg[rd_idx];
        end
        if (cmd.capture) begin
            acc_reg <= '0;
        end else if (cmd.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.err_en) begin
            err_reg <= err_next;
            obs_reg <= obs_next;
        end
        if (cmd.out_load) begin
            out_obs_reg <= cmd.out_zero ? 1'b0 : obs_reg;
            out_err_reg <= cmd.out_zero ? '0 : err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_err_reg, out_obs_reg};

endmodule
